// ===== design/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, constants and helper functions for the triangle
// versus circle hit test.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int SINE_TABLE_DEPTH_DEF = 256;
  localparam int QUEUE_DEPTH          = 4;
  localparam int QCNT_W               = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W               = $clog2(QUEUE_DEPTH);

  localparam logic [11:0] SHIP_SCALE_RESET = 12'd256;
  localparam logic        REG_SHIP_SCALE   = 1'b0;

  localparam logic [63:0] Q30_C1 = 64'd1686629713;
  localparam logic [63:0] Q30_C3 = 64'd693598668;
  localparam logic [63:0] Q30_C5 = 64'd85569306;
  localparam logic [63:0] Q30_C7 = 64'd5026994;
  localparam logic [63:0] Q30_C9 = 64'd172272;

  // Vertex coordinate, Q4 pixels, wide enough for the ship position plus offset.
  typedef logic signed [17:0] coord_t;

  // Local vertex offsets that follow from the ship scale.
  typedef struct packed {
    logic [8:0] half;
    logic [8:0] nose;
    logic [7:0] tail;
  } offs_t;

  // One item after the front end: placed vertices and the circle.
  typedef struct packed {
    coord_t [2:0] vx;
    coord_t [2:0] vy;
    logic [15:0]  cx;
    logic [15:0]  cy;
    logic [16:0]  rad;
  } vert_t;

  // Sine of a 16-bit phase in signed Q1.14, odd polynomial on the quarter wave.
  function automatic logic signed [15:0] quarter_sine(input logic [15:0] phase);
    logic [1:0]  quad;
    logic [63:0] f;
    logic [63:0] t30;
    logic [63:0] t2;
    logic [63:0] p;
    logic [63:0] v;
    quad = phase[15:14];
    f    = {50'd0, phase[13:0]};
    if (quad[0]) begin
      f = 64'd16384 - f;
    end
    t30 = f << 16;
    t2  = (t30 * t30) >> 30;
    p   = Q30_C9;
    p   = Q30_C7 - ((p * t2) >> 30);
    p   = Q30_C5 - ((p * t2) >> 30);
    p   = Q30_C3 - ((p * t2) >> 30);
    p   = Q30_C1 - ((p * t2) >> 30);
    v   = (((p * t30) >> 30) + 64'd32768) >> 16;
    if (v > 64'd16384) begin
      v = 64'd16384;
    end
    return quad[1] ? -v[15:0] : v[15:0];
  endfunction

  // Offsets rounded half up to Q4: scale (Q8) times a Q16 constant.
  function automatic offs_t calc_offs(input logic [11:0] s);
    offs_t       o;
    logic [31:0] sw;
    logic [31:0] t;
    sw     = {20'd0, s};
    t      = (sw * 32'd32768 + 32'd524288) >> 20;
    o.half = t[8:0];
    t      = (sw * 32'd37814 + 32'd524288) >> 20;
    o.nose = t[8:0];
    t      = (sw * 32'd18918 + 32'd524288) >> 20;
    o.tail = t[7:0];
    return o;
  endfunction

endpackage

// ===== design/tcc_front.sv =====
// ----------------------------------------------------------------------------
// tcc_front
// Takes an item, looks up sine and cosine of the heading and places the three
// triangle vertices; the result passes the look-up and product registers and then goes into the queue.
// ----------------------------------------------------------------------------
module tcc_front
  import tcc_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [15:0]       in_ship_x,
  input  logic [15:0]       in_ship_y,
  input  logic [15:0]       in_heading,
  input  logic [15:0]       in_circle_x,
  input  logic [15:0]       in_circle_y,
  input  logic [11:0]       in_circle_scale,
  input  offs_t             offs,
  input  logic [QCNT_W-1:0] q_count,
  output logic              busy,
  output logic              push,
  output vert_t             push_data
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int DEP_W  = IDX_W + 1;
  localparam int PROD_W = 16 + DEP_W;

  typedef logic signed [15:0] tab_t [SINE_TABLE_DEPTH];

  function automatic tab_t build_tab(input logic cos_sel);
    tab_t        t;
    logic [31:0] ph;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      ph = 32'((i * 65536) / SINE_TABLE_DEPTH);
      if (cos_sel) begin
        ph = ph + 32'd16384;
      end
      t[i] = quarter_sine(ph[15:0]);
    end
    return t;
  endfunction

  localparam tab_t SIN_TAB = build_tab(1'b0);
  localparam tab_t COS_TAB = build_tab(1'b1);

  logic                accept;
  logic [PROD_W-1:0]   idx_prod;
  logic [IDX_W-1:0]    idx;

  logic                v0_r, v1_r;
  logic signed [15:0]  sn_r, cn_r;
  logic [15:0]         sx0_r, sy0_r, cx0_r, cy0_r;
  logic [16:0]         rad0_r;
  logic [15:0]         sx1_r, sy1_r, cx1_r, cy1_r;
  logic [16:0]         rad1_r;
  logic signed [25:0]  p_nsn_r, p_ncn_r, p_hsn_r, p_hcn_r, p_tsn_r, p_tcn_r;

  logic signed [26:0]  sum_x [3];
  logic signed [26:0]  sum_y [3];
  logic signed [26:0]  rnd_x, rnd_y;

  logic [QCNT_W+1:0]   occupancy;

  // Items in flight count against the queue so that a pushed item always fits.
  assign occupancy = (QCNT_W + 2)'(q_count) + (QCNT_W + 2)'(v0_r) + (QCNT_W + 2)'(v1_r);
  assign busy      = occupancy >= (QCNT_W + 2)'(QUEUE_DEPTH);
  assign accept    = start && !busy;

  assign idx_prod = PROD_W'(in_heading) * PROD_W'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[IDX_W+15:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= accept;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    sn_r   <= SIN_TAB[idx];
    cn_r   <= COS_TAB[idx];
    sx0_r  <= in_ship_x;
    sy0_r  <= in_ship_y;
    cx0_r  <= in_circle_x;
    cy0_r  <= in_circle_y;
    rad0_r <= 17'(in_circle_scale) * 17'd25;
  end

  always_ff @(posedge clk) begin
    p_nsn_r <= $signed({1'b0, offs.nose}) * sn_r;
    p_ncn_r <= $signed({1'b0, offs.nose}) * cn_r;
    p_hsn_r <= $signed({1'b0, offs.half}) * sn_r;
    p_hcn_r <= $signed({1'b0, offs.half}) * cn_r;
    p_tsn_r <= $signed({2'b00, offs.tail}) * sn_r;
    p_tcn_r <= $signed({2'b00, offs.tail}) * cn_r;
    sx1_r   <= sx0_r;
    sy1_r   <= sy0_r;
    cx1_r   <= cx0_r;
    cy1_r   <= cy0_r;
    rad1_r  <= rad0_r;
  end

  // Nose at (0, -nose), tail corners at (+-half, tail), rotated by the heading.
  always_comb begin
    sum_x[0] = 27'(p_nsn_r);
    sum_y[0] = -27'(p_ncn_r);
    sum_x[1] = 27'(p_hcn_r) - 27'(p_tsn_r);
    sum_y[1] = 27'(p_hsn_r) + 27'(p_tcn_r);
    sum_x[2] = -27'(p_hcn_r) - 27'(p_tsn_r);
    sum_y[2] = -27'(p_hsn_r) + 27'(p_tcn_r);
    push_data.cx  = cx1_r;
    push_data.cy  = cy1_r;
    push_data.rad = rad1_r;
    for (int i = 0; i < 3; i++) begin
      rnd_x = (sum_x[i] + 27'sd8192) >>> 14;
      rnd_y = (sum_y[i] + 27'sd8192) >>> 14;
      push_data.vx[i] = coord_t'({2'b00, sx1_r}) + coord_t'(rnd_x[17:0]);
      push_data.vy[i] = coord_t'({2'b00, sy1_r}) + coord_t'(rnd_y[17:0]);
    end
  end

  assign push = v1_r;

endmodule

// ===== design/tcc_queue.sv =====
// ----------------------------------------------------------------------------
// tcc_queue
// Short register queue between the vertex front end and the hit back end.
// ----------------------------------------------------------------------------
module tcc_queue
  import tcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  vert_t             push_data,
  output logic              pop,
  output vert_t             pop_data,
  output logic [QCNT_W-1:0] count
);

  vert_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  // The back end never stalls, so the head leaves as soon as it is there.
  assign pop      = cnt_r != '0;
  assign pop_data = mem_r[rd_r];
  assign count    = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= (wr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == QCNT_W'(QUEUE_DEPTH)))
    else $error("queue written while full");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

// ===== design/tcc_back.sv =====
// ----------------------------------------------------------------------------
// tcc_back
// Vertex, edge and inside tests on the placed triangle, six register stages.
// ----------------------------------------------------------------------------
module tcc_back
  import tcc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  pop,
  input  vert_t pop_data,
  output logic  out_valid,
  output logic  out_hit
);

  // Edge ends for the edge test, and the next vertex for the inside test.
  localparam int EA [3] = '{0, 0, 1};
  localparam int EB [3] = '{1, 2, 2};
  localparam int NX [3] = '{1, 2, 0};

  logic [5:0] val_r;

  logic signed [18:0] vx19 [3];
  logic signed [18:0] vy19 [3];
  logic signed [18:0] tmp;

  // Stage 1: differences.
  logic signed [18:0] dx_r [3], dy_r [3];
  logic signed [11:0] ex_r [3], ey_r [3], ix_r [3], iy_r [3];
  logic [16:0]        rad_r;
  logic signed [11:0] ex_nxt [3], ey_nxt [3], ix_nxt [3], iy_nxt [3];

  // Stage 2: products.
  logic [37:0]        sqdx_r [3], sqdy_r [3];
  logic [23:0]        sqex_r [3], sqey_r [3];
  logic signed [30:0] cra_r [3], crb_r [3], ina_r [3], inb_r [3];
  logic signed [23:0] ar1_r, ar2_r;
  logic [33:0]        r2a_r;

  // Stage 3: sums.
  logic [38:0]        d_r [3];
  logic [24:0]        ab_r [3];
  logic signed [31:0] cr_r [3], e_r [3];
  logic signed [24:0] area_r;
  logic [33:0]        r2b_r;

  // Stage 4: compares.
  logic [2:0]         proj_r;
  logic [2:0]         proj_nxt;
  logic [22:0]        mag_r [3];
  logic [24:0]        abc_r [3];
  logic [33:0]        r2c_r;
  logic               near_r;
  logic [31:0]        mag_full [3];
  logic               vhit, any_neg, any_pos;

  // Stage 5: wide products.
  logic [2:0]         prj_r;
  logic [45:0]        m2_r [3];
  logic [58:0]        rab_r [3];
  logic               near2_r;

  // Stage 6: result.
  logic               hit_r;
  logic [2:0]         ehit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= {val_r[4:0], pop};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx19[i] = {pop_data.vx[i][17], pop_data.vx[i]};
      vy19[i] = {pop_data.vy[i][17], pop_data.vy[i]};
    end
    for (int k = 0; k < 3; k++) begin
      tmp       = vx19[EB[k]] - vx19[EA[k]];
      ex_nxt[k] = tmp[11:0];
      tmp       = vy19[EB[k]] - vy19[EA[k]];
      ey_nxt[k] = tmp[11:0];
      tmp       = vx19[NX[k]] - vx19[k];
      ix_nxt[k] = tmp[11:0];
      tmp       = vy19[NX[k]] - vy19[k];
      iy_nxt[k] = tmp[11:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dx_r[i] <= $signed({3'b000, pop_data.cx}) - vx19[i];
      dy_r[i] <= $signed({3'b000, pop_data.cy}) - vy19[i];
      ex_r[i] <= ex_nxt[i];
      ey_r[i] <= ey_nxt[i];
      ix_r[i] <= ix_nxt[i];
      iy_r[i] <= iy_nxt[i];
    end
    rad_r <= pop_data.rad;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sqdx_r[i] <= dx_r[i] * dx_r[i];
      sqdy_r[i] <= dy_r[i] * dy_r[i];
      sqex_r[i] <= ex_r[i] * ex_r[i];
      sqey_r[i] <= ey_r[i] * ey_r[i];
      cra_r[i]  <= dx_r[EA[i]] * ey_r[i];
      crb_r[i]  <= dy_r[EA[i]] * ex_r[i];
      ina_r[i]  <= ix_r[i] * dy_r[i];
      inb_r[i]  <= iy_r[i] * dx_r[i];
    end
    ar1_r <= ex_r[0] * ey_r[1];
    ar2_r <= ey_r[0] * ex_r[1];
    r2a_r <= 34'(rad_r) * 34'(rad_r);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d_r[i]  <= {1'b0, sqdx_r[i]} + {1'b0, sqdy_r[i]};
      ab_r[i] <= {1'b0, sqex_r[i]} + {1'b0, sqey_r[i]};
      cr_r[i] <= 32'(cra_r[i]) - 32'(crb_r[i]);
      e_r[i]  <= 32'(ina_r[i]) - 32'(inb_r[i]);
    end
    area_r <= 25'(ar1_r) - 25'(ar2_r);
    r2b_r  <= r2a_r;
  end

  // A cross product of 2^23 or more squares to more than any radius times
  // edge length can reach, so such an edge is simply out of range.
  always_comb begin
    vhit    = 1'b0;
    any_neg = 1'b0;
    any_pos = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag_full[i] = cr_r[i][31] ? 32'(-cr_r[i]) : 32'(cr_r[i]);
      proj_nxt[i] = (ab_r[i] != '0) && (mag_full[i][31:23] == '0)
                 && (40'(d_r[EA[i]]) <= 40'(ab_r[i]) + 40'(d_r[EB[i]]))
                 && (40'(d_r[EB[i]]) <= 40'(ab_r[i]) + 40'(d_r[EA[i]]));
      if ({d_r[i], 8'd0} <= 47'(r2b_r)) begin
        vhit = 1'b1;
      end
      if (e_r[i] < 0) begin
        any_neg = 1'b1;
      end
      if (e_r[i] > 0) begin
        any_pos = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag_r[i] <= mag_full[i][22:0];
      abc_r[i] <= ab_r[i];
    end
    proj_r <= proj_nxt;
    r2c_r  <= r2b_r;
    near_r <= vhit || ((area_r != '0) && !(any_neg && any_pos));
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m2_r[i]  <= 46'(mag_r[i]) * 46'(mag_r[i]);
      rab_r[i] <= 59'(r2c_r) * 59'(abc_r[i]);
    end
    prj_r   <= proj_r;
    near2_r <= near_r;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ehit[i] = prj_r[i] && (59'({m2_r[i], 8'd0}) <= rab_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= near2_r || (|ehit);
  end

  assign out_valid = val_r[5];
  assign out_hit   = hit_r;

endmodule

// ===== design/triangle_circle_collision.sv =====
// ----------------------------------------------------------------------------
// triangle_circle_collision
// Hit test of a rotated, scaled ship triangle against a circle.
//
//   channel   handshake               payload
//   input     start / busy            in_ship_x/y, in_heading, in_circle_x/y,
//                                     in_circle_scale
//   result    out_valid (strobe)      out_hit
//   config    psel/penable/pwrite     paddr, pwdata, prdata; ship_scale at 0
//
// One item is taken every cycle while busy is low; each gives one result after
// table look-up and vertex placement in the front end, a pass through the
// queue, and the distance and cross-product test stages.
// Reset is synchronous; it empties the pipeline and sets ship_scale to 1.0.
// The result side cannot stall, so the queue drains every cycle and busy
// stays low in normal use.
// ----------------------------------------------------------------------------
module triangle_circle_collision
  import tcc_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_ship_x,
  input  logic [15:0] in_ship_y,
  input  logic [15:0] in_heading,
  input  logic [15:0] in_circle_x,
  input  logic [15:0] in_circle_y,
  input  logic [11:0] in_circle_scale,
  output logic        out_valid,
  output logic        out_hit,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [11:0]       ship_scale_r;
  offs_t             offs_r;
  logic              push, pop;
  vert_t             push_data, pop_data;
  logic [QCNT_W-1:0] q_count;
  logic              wr_scale;

  assign pready   = 1'b1;
  assign wr_scale = psel && penable && pwrite && (paddr[2] == REG_SHIP_SCALE);
  assign prdata   = (paddr[2] == REG_SHIP_SCALE) ? {20'd0, ship_scale_r} : 32'd0;

  // The vertex offsets depend on the scale alone, so they are worked out here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ship_scale_r <= SHIP_SCALE_RESET;
      offs_r       <= calc_offs(SHIP_SCALE_RESET);
    end else if (wr_scale) begin
      ship_scale_r <= pwdata[11:0];
      offs_r       <= calc_offs(pwdata[11:0]);
    end
  end

  tcc_front #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_ship_x       (in_ship_x),
    .in_ship_y       (in_ship_y),
    .in_heading      (in_heading),
    .in_circle_x     (in_circle_x),
    .in_circle_y     (in_circle_y),
    .in_circle_scale (in_circle_scale),
    .offs            (offs_r),
    .q_count         (q_count),
    .busy            (busy),
    .push            (push),
    .push_data       (push_data)
  );

  tcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .count     (q_count)
  );

  tcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_hit   (out_hit)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##9 out_valid)
    else $error("result strobe missing nine cycles after an accepted item");

endmodule
